[sv/lmcs_pkg.sv]
// Package for the LED matrix column scanner: item and result types,
// configuration types, function codes and register indexes.
// No dependencies.
package lmcs_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic REG_DRIVE_MODE  = 1'b0;
  localparam logic REG_DWELL_TICKS = 1'b1;

  localparam logic [15:0] DWELL_RESET = 16'd2500;
  localparam logic [15:0] DWELL_MIN   = 16'd2;

  // Division of a 16-bit duration by 20 as a multiply by ceil(2^20 / 20).
  localparam logic [16:0] DIV20_RECIP = 17'd52429;
  localparam int          DIV20_SHIFT = 20;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  column_index;
    logic [7:0]  row_bits;
    logic [15:0] duration_ms;
  } item_t;

  typedef struct packed {
    logic [7:0]  row_drive;
    logic [7:0]  column_drive;
    logic [15:0] shift_word;
    logic        shift_load;
    logic        busy_res;
    logic        frame_done;
  } result_t;

  typedef struct packed {
    logic        drive_mode;
    logic [15:0] dwell_ticks;
  } cfg_t;

endpackage

[sv/led_matrix_column_scanner_top.sv]
// Top level of the LED matrix column scanner: input stage, scan state,
// frame store and result register. Depends on lmcs_pkg and lmcs_regs.
//
//   Channel   Signals                          Payload
//   item      item_valid, item_stall           item (lmcs_pkg::item_t)
//   result    result_valid, result_stall       result (lmcs_pkg::result_t)
//   config    psel, penable, pwrite, paddr...  pwdata / prdata, 32 bits
//
// An item waits in the input register and its result is then written to the
// result register; one item is taken every cycle while the result is not
// stalled. The scan state updates as the item leaves the input register, so
// a following item sees it at once. Reset clears the frame store, the scan
// state and the valid flags of the input and result registers. A stalled
// result holds the result register, and the input register once it is full.
module led_matrix_column_scanner_top #(
  parameter int COLUMNS = 8,
  parameter int ROWS    = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  lmcs_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output lmcs_pkg::result_t   result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int          SCW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [7:0]  ROW_MASK = 8'(((1 << ROWS) - 1) & 255);
  localparam logic [SCW-1:0] LAST_COL = SCW'(COLUMNS - 1);

  lmcs_pkg::cfg_t    cfg;
  lmcs_pkg::item_t   stg;
  lmcs_pkg::result_t res_next;

  logic              stg_valid;
  logic              stg_load;
  logic              advance;
  logic              step;

  logic [7:0]        frame_store [COLUMNS];
  logic [SCW-1:0]    scan_column;
  logic [15:0]       dwell_count;
  logic [11:0]       frames_left;
  logic              active_flag;

  logic [SCW-1:0]    scan_column_next;
  logic [15:0]       dwell_count_next;
  logic [11:0]       frames_left_next;
  logic              active_flag_next;

  logic [SCW+2:0]    col_wide;
  logic              col_ok;
  logic [32:0]       div_prod;
  logic [11:0]       frame_count;
  logic [15:0]       dwell;
  logic [16:0]       dwell_inc;
  logic [15:0]       col_bit;
  logic [7:0]        data;
  logic [11:0]       frames_dec;

  lmcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance    = !result_valid || !result_stall;
  assign stg_load   = !stg_valid || advance;
  assign item_stall = !stg_load;
  assign step       = stg_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (stg_load) begin
      stg_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_load && item_valid) begin
      stg <= item;
    end
  end

  assign col_wide    = (SCW + 3)'(stg.column_index);
  assign col_ok      = 32'(stg.column_index) < 32'(COLUMNS);
  assign div_prod    = 33'(stg.duration_ms) * 33'(lmcs_pkg::DIV20_RECIP);
  assign frame_count = div_prod[lmcs_pkg::DIV20_SHIFT +: 12];
  assign dwell       = (cfg.dwell_ticks < lmcs_pkg::DWELL_MIN) ? lmcs_pkg::DWELL_MIN
                                                               : cfg.dwell_ticks;
  assign dwell_inc   = 17'(dwell_count) + 17'd1;
  assign col_bit     = 16'd1 << scan_column;
  assign data        = frame_store[scan_column] & ROW_MASK;
  assign frames_dec  = (frames_left != 12'd0) ? frames_left - 12'd1 : frames_left;

  always_comb begin
    scan_column_next = scan_column;
    dwell_count_next = dwell_count;
    frames_left_next = frames_left;
    active_flag_next = active_flag;
    res_next         = '0;

    unique case (stg.func)
      lmcs_pkg::FUNC_START: begin
        frames_left_next = frame_count;
        scan_column_next = '0;
        dwell_count_next = '0;
        active_flag_next = (frame_count != 12'd0);
      end
      lmcs_pkg::FUNC_TICK: begin
        if (active_flag) begin
          if (dwell_count == 16'd0) begin
            res_next.shift_load = cfg.drive_mode;
          end else if (cfg.drive_mode) begin
            if (dwell_count == 16'd1) begin
              res_next.shift_word = {col_bit[7:0], data};
              res_next.shift_load = 1'b1;
            end
          end else begin
            res_next.row_drive    = data;
            res_next.column_drive = col_bit[7:0];
          end

          if (dwell_inc >= 17'(dwell)) begin
            dwell_count_next = '0;
            if (scan_column == LAST_COL) begin
              scan_column_next = '0;
              frames_left_next = frames_dec;
              if (frames_dec == 12'd0) begin
                active_flag_next    = 1'b0;
                res_next.frame_done = 1'b1;
              end
            end else begin
              scan_column_next = scan_column + SCW'(1);
            end
          end else begin
            dwell_count_next = dwell_inc[15:0];
          end
        end
      end
      default: ;
    endcase

    res_next.busy_res = active_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column <= '0;
      dwell_count <= '0;
      frames_left <= '0;
      active_flag <= 1'b0;
      for (int i = 0; i < COLUMNS; i++) begin
        frame_store[i] <= '0;
      end
    end else if (step) begin
      scan_column <= scan_column_next;
      dwell_count <= dwell_count_next;
      frames_left <= frames_left_next;
      active_flag <= active_flag_next;
      if (stg.func == lmcs_pkg::FUNC_WRITE && col_ok) begin
        frame_store[col_wide[SCW-1:0]] <= stg.row_bits & ROW_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= res_next;
    end
  end

endmodule

[sv/lmcs_regs.sv]
// Configuration register file of the LED matrix column scanner on an
// APB-style port. Depends on lmcs_pkg for the register indexes and cfg_t.
module lmcs_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output lmcs_pkg::cfg_t      cfg
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_mode  <= 1'b0;
      cfg.dwell_ticks <= lmcs_pkg::DWELL_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        lmcs_pkg::REG_DRIVE_MODE:  cfg.drive_mode  <= pwdata[0];
        lmcs_pkg::REG_DWELL_TICKS: cfg.dwell_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      lmcs_pkg::REG_DRIVE_MODE:  prdata = {31'd0, cfg.drive_mode};
      lmcs_pkg::REG_DWELL_TICKS: prdata = {16'd0, cfg.dwell_ticks};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule
